@@ design/pd_pkg.sv @@
// Package for the packet deframer: frame byte codes, phase and event enums,
// and the result record passed from the parser to the output register.
// No dependencies.
package pd_pkg;

  localparam logic [7:0]  HeadByte      = 8'hAA;
  localparam logic [7:0]  VerifyByte    = 8'h41;
  localparam logic [7:0]  TailByte      = 8'hFF;
  localparam logic [16:0] FrameOverhead = 17'd7;
  localparam logic [16:0] MaxLenReset   = 17'd4096;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_VERIFY  = 3'd1,
    PH_SEQ     = 3'd2,
    PH_CMD     = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_LEN_HI  = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_TAIL    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_OK       = 2'd1,
    EV_NO_TAIL  = 2'd2,
    EV_TOO_LONG = 2'd3
  } event_e;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  data_byte;
    logic [7:0]  command;
    logic [7:0]  sequence_res;
    logic [15:0] payload_len;
    logic        frame_end;
  } pd_result_t;

endpackage

@@ design/pd_parse.sv @@
// Frame parser: phase state machine plus the captured header fields.
// Builds the result for the byte held in the input register. Uses pd_pkg.
module pd_parse import pd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [16:0] max_len_i,
  output logic        has_result_o,
  output pd_result_t  result_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [15:0] count_inc;
  logic [15:0] len_full;
  logic [16:0] pkt_total;

  assign count_inc = count_q + 16'd1;
  assign len_full  = {byte_i, len_q[7:0]};
  assign pkt_total = {1'b0, len_q} + FrameOverhead;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_HUNT:    if (byte_i == HeadByte) phase_d = PH_VERIFY;
      PH_VERIFY:  if (byte_i == VerifyByte) phase_d = PH_SEQ;
      PH_SEQ:     phase_d = PH_CMD;
      PH_CMD:     phase_d = PH_LEN_LO;
      PH_LEN_LO:  phase_d = PH_LEN_HI;
      PH_LEN_HI:  phase_d = (len_full == 16'd0) ? PH_TAIL : PH_PAYLOAD;
      PH_PAYLOAD: if (count_inc >= len_q) phase_d = PH_TAIL;
      PH_TAIL:    phase_d = PH_HUNT;
      default:    phase_d = PH_HUNT;
    endcase
  end

  // Header captures and the result for this byte.
  always_comb begin
    seq_d                 = seq_q;
    cmd_d                 = cmd_q;
    len_d                 = len_q;
    count_d               = count_q;
    has_result_o          = 1'b0;
    result_o.event_res    = EV_DATA;
    result_o.data_byte    = 8'd0;
    result_o.command      = cmd_q;
    result_o.sequence_res = seq_q;
    result_o.payload_len  = len_q;
    result_o.frame_end    = 1'b0;
    unique case (phase_q)
      PH_SEQ:    seq_d = byte_i;
      PH_CMD:    cmd_d = byte_i;
      PH_LEN_LO: len_d = {8'd0, byte_i};
      PH_LEN_HI: begin
        len_d   = len_full;
        count_d = 16'd0;
      end
      PH_PAYLOAD: begin
        count_d            = count_inc;
        has_result_o       = 1'b1;
        result_o.data_byte = byte_i;
      end
      PH_TAIL: begin
        has_result_o       = 1'b1;
        result_o.frame_end = 1'b1;
        // A bad tail outranks the length check.
        if (byte_i != TailByte) begin
          result_o.event_res = EV_NO_TAIL;
        end else if (pkt_total > max_len_i) begin
          result_o.event_res = EV_TOO_LONG;
        end else begin
          result_o.event_res = EV_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      seq_q   <= 8'd0;
      cmd_q   <= 8'd0;
      len_q   <= 16'd0;
      count_q <= 16'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      count_q <= count_d;
    end
  end

  a_tail_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_TAIL |=> phase_q == PH_HUNT)
    else $error("tail byte did not return the parser to hunting");

  a_end_matches_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_result_o |-> (result_o.frame_end == (result_o.event_res != EV_DATA)))
    else $error("frame end flag disagrees with the event");

  a_status_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_result_o && result_o.event_res != EV_DATA |-> result_o.data_byte == 8'd0)
    else $error("status result carries a nonzero data byte");

  a_result_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_result_o |-> (phase_q == PH_PAYLOAD || phase_q == PH_TAIL))
    else $error("result produced outside payload or tail");

endmodule

@@ design/pd_out_reg.sv @@
// Result register of the deframer: holds one result until the downstream
// side takes it, and loads a new one in the same cycle it drains. Uses pd_pkg.
module pd_out_reg import pd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  pd_result_t result_i,
  output logic       can_load_o,
  output logic       valid_o,
  input  logic       ready_i,
  output pd_result_t result_o
);

  logic       valid_q, valid_d;
  pd_result_t result_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ design/packet_deframer_top.sv @@
// Packet deframer top level: input byte register, frame parser, result register
// and the max_packet_len configuration register. Uses pd_pkg, pd_parse, pd_out_reg.

// The deframer takes one received byte per cycle. Each accepted byte sits in the
// input register while the phase state machine classifies it; a payload byte or
// end-of-frame status is then loaded into the result register, which drives the
// output. Header bytes produce no result. The input stalls only when the held
// byte produces a result and the result register holds one that is not taken in
// that cycle, so full rate holds as long as results are taken as they appear.
module packet_deframer_top import pd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  command_o,
  output logic [7:0]  sequence_res_o,
  output logic [15:0] payload_len_o,
  output logic        frame_end_o
);

  logic [16:0] max_len_q;
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        advance;
  logic        has_result;
  logic        out_can_load;
  pd_result_t  parse_result;
  pd_result_t  out_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  // A held byte moves on unless it needs the result register and that is full.
  assign advance    = in_valid_q && (!has_result || out_can_load);
  assign in_ready_o = !in_valid_q || advance;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  pd_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .max_len_i    (max_len_q),
    .has_result_o (has_result),
    .result_o     (parse_result)
  );

  pd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && has_result),
    .result_i   (parse_result),
    .can_load_o (out_can_load),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .result_o   (out_result)
  );

  assign event_res_o    = out_result.event_res;
  assign data_byte_o    = out_result.data_byte;
  assign command_o      = out_result.command;
  assign sequence_res_o = out_result.sequence_res;
  assign payload_len_o  = out_result.payload_len;
  assign frame_end_o    = out_result.frame_end;

  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && has_result |-> out_can_load)
    else $error("result loaded over an untaken result");

  a_stall_only_for_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> has_result && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_held_byte_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("stalled input byte changed");

endmodule

@@ test/packet_deframer_top_test.sv @@
// Self-checking testbench for packet_deframer_top: directed frames from a table, then random
// framed byte streams under several max_packet_len settings, checked by a local frame parser.
// Depends on pd_pkg and packet_deframer_top.
module packet_deframer_top_test import pd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_SPARSE,
    RX_PERIODIC,
    RX_HALF
  } rx_mode_e;

  typedef struct {
    bit          is_cfg;
    logic [16:0] value;
    bit          typed;
    pd_result_t  want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  event_res_o;
  logic [7:0]  data_byte_o;
  logic [7:0]  command_o;
  logic [7:0]  sequence_res_o;
  logic [15:0] payload_len_o;
  logic        frame_end_o;

  // Local copy of the parser state and of the length limit.
  phase_e      fr_phase = PH_HUNT;
  logic [7:0]  fr_seq   = 8'h00;
  logic [7:0]  fr_cmd   = 8'h00;
  logic [15:0] fr_len   = 16'h0000;
  logic [15:0] fr_count = 16'h0000;
  logic [16:0] lim_len  = MaxLenReset;

  pd_result_t  pending_results[$];
  logic [7:0]  frame_bytes[$];
  row_t        script[$];
  int          mismatches   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_req    = 0;
  int unsigned stall_served = 0;

  packet_deframer_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .data_byte_o    (data_byte_o),
    .command_o      (command_o),
    .sequence_res_o (sequence_res_o),
    .payload_len_o  (payload_len_o),
    .frame_end_o    (frame_end_o)
  );

  always #10 clk = ~clk;

  // Steps the local parser by one byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output pd_result_t r);
    bit          has;
    logic [16:0] whole;
    has = 1'b0;
    r   = '0;
    case (fr_phase)
      PH_HUNT: begin
        if (b == HeadByte) fr_phase = PH_VERIFY;
      end
      PH_VERIFY: begin
        if (b == VerifyByte) fr_phase = PH_SEQ;
      end
      PH_SEQ: begin
        fr_seq   = b;
        fr_phase = PH_CMD;
      end
      PH_CMD: begin
        fr_cmd   = b;
        fr_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        fr_len   = {8'h00, b};
        fr_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        fr_len   = {b, fr_len[7:0]};
        fr_count = 16'h0000;
        fr_phase = (fr_len == 16'h0000) ? PH_TAIL : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        fr_count = fr_count + 16'd1;
        if (fr_count >= fr_len) fr_phase = PH_TAIL;
        r.event_res = EV_DATA;
        r.data_byte = b;
        has = 1'b1;
      end
      default: begin
        whole = {1'b0, fr_len} + FrameOverhead;
        // A bad tail wins over the length check.
        if (b != TailByte) begin
          r.event_res = EV_NO_TAIL;
        end else if (whole > lim_len) begin
          r.event_res = EV_TOO_LONG;
        end else begin
          r.event_res = EV_OK;
        end
        r.frame_end = 1'b1;
        fr_phase    = PH_HUNT;
        has = 1'b1;
      end
    endcase
    if (has) begin
      r.command      = fr_cmd;
      r.sequence_res = fr_seq;
      r.payload_len  = fr_len;
    end
    return has;
  endfunction

  function automatic pd_result_t res(input event_e ev, input logic [7:0] d, input logic [7:0] c,
                                     input logic [7:0] s, input logic [15:0] l, input logic f);
    pd_result_t r;
    r.event_res    = ev;
    r.data_byte    = d;
    r.command      = c;
    r.sequence_res = s;
    r.payload_len  = l;
    r.frame_end    = f;
    return r;
  endfunction

  function automatic void add_row(input bit is_cfg, input logic [16:0] v, input bit typed,
                                  input pd_result_t w);
    row_t r;
    r.is_cfg = is_cfg;
    r.value  = v;
    r.typed  = typed;
    r.want   = w;
    script.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one byte in the sender's burst pattern and records what it should produce.
  task automatic send_byte(input logic [7:0] b, input bit typed, input pd_result_t want);
    pd_result_t got;
    bit         has;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk); while (!in_ready_o);
    bytes_sent++;
    has = deframe_byte(b, got);
    if (typed) begin
      pending_results.push_back(want);
    end else if (has) begin
      pending_results.push_back(got);
    end
  endtask

  // Waits until every expected result is back and the header pipeline has drained.
  task automatic settle_idle();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_max_len(input logic [16:0] v);
    settle_idle();
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk); while (!cfg_ready_o);
    lim_len = v;
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  task automatic build_frame(input int unsigned plen, input bit good_tail);
    logic [7:0] v;
    frame_bytes.delete();
    repeat ($urandom_range(0, 2)) begin
      do v = 8'($urandom); while (v == HeadByte);
      frame_bytes.push_back(v);
    end
    frame_bytes.push_back(HeadByte);
    // Junk between head and verify byte, possibly a second head.
    repeat ($urandom_range(0, 2)) begin
      do v = 8'($urandom); while (v == VerifyByte);
      frame_bytes.push_back(v);
    end
    frame_bytes.push_back(VerifyByte);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(plen[7:0]);
    frame_bytes.push_back(plen[15:8]);
    repeat (plen) frame_bytes.push_back(8'($urandom));
    if (good_tail) begin
      frame_bytes.push_back(TailByte);
    end else begin
      do v = 8'($urandom); while (v == TailByte);
      frame_bytes.push_back(v);
    end
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, '0);
  endtask

  task automatic random_phase(input int p);
    int unsigned phase_start;
    int unsigned plen;
    int unsigned pick;
    int          near;
    bit          paused;
    phase_start = bytes_sent;
    paused      = 1'b0;
    while (bytes_sent - phase_start < 130) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        plen = $urandom_range(0, 8);
      end else if (pick < 75) begin
        plen = $urandom_range(9, 40);
      end else if (pick < 87 && lim_len >= 7 && lim_len <= 60) begin
        // Straddle the length limit.
        near = int'(lim_len) - 8 + int'($urandom_range(0, 2));
        plen = (near < 0) ? 0 : near;
      end else if (pick < 91) begin
        plen = $urandom_range(200, 700);
      end else begin
        plen = $urandom_range(0, 3);
      end
      if ($urandom_range(0, 19) == 0) begin
        // Plain noise on the line.
        frame_bytes.delete();
        repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
      end else begin
        build_frame(plen, $urandom_range(0, 99) < 85);
        if ($urandom_range(0, 99) < 8) begin
          repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
        end
      end
      send_frame_bytes();
      if (p == 1 && !paused && bytes_sent - phase_start >= 60) begin
        settle_idle();
        paused = 1'b1;
      end
    end
  endtask

  // Receiver: changing stall patterns, plus long hold-offs on request.
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode        = RX_FREE;
    mode_left   = 0;
    hold_left   = 0;
    tick        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (stall_req != stall_served) begin
        stall_served++;
        hold_left   = 400;
        out_ready_i = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          RX_FREE:     out_ready_i = 1'b1;
          RX_SPARSE:   out_ready_i = ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_ready_i = (tick % 3 != 0);
          default:     out_ready_i = $urandom_range(0, 1);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    pd_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: event %0d data %0h end %0b",
               event_res_o, data_byte_o, frame_end_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", 16'(want.event_res), 16'(event_res_o));
        check_field("data_byte", 16'(want.data_byte), 16'(data_byte_o));
        check_field("command", 16'(want.command), 16'(command_o));
        check_field("sequence_res", 16'(want.sequence_res), 16'(sequence_res_o));
        check_field("payload_len", want.payload_len, payload_len_o);
        check_field("frame_end", 16'(want.frame_end), 16'(frame_end_o));
      end
    end
  end

  initial begin
    #80ms;
    $display("packet_deframer_top_test: errors");
    $finish;
  end

  initial begin
    int waited;
    int p;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;

    // Directed frames: junk and a second head in verify, extreme bytes, zero length, bad tail, too long.
    add_row(1'b0, 17'h00, 1'b0, '0);
    add_row(1'b0, 17'hAA, 1'b0, '0);
    add_row(1'b0, 17'h13, 1'b0, '0);
    add_row(1'b0, 17'hAA, 1'b0, '0);
    add_row(1'b0, 17'h41, 1'b0, '0);
    add_row(1'b0, 17'hFF, 1'b0, '0);
    add_row(1'b0, 17'h00, 1'b0, '0);
    add_row(1'b0, 17'h02, 1'b0, '0);
    add_row(1'b0, 17'h00, 1'b0, '0);
    add_row(1'b0, 17'h00, 1'b1, res(EV_DATA, 8'h00, 8'h00, 8'hFF, 16'd2, 1'b0));
    add_row(1'b0, 17'hFF, 1'b1, res(EV_DATA, 8'hFF, 8'h00, 8'hFF, 16'd2, 1'b0));
    add_row(1'b0, 17'hFF, 1'b1, res(EV_OK, 8'h00, 8'h00, 8'hFF, 16'd2, 1'b1));
    add_row(1'b0, 17'hAA, 1'b0, '0);
    add_row(1'b0, 17'h41, 1'b0, '0);
    add_row(1'b0, 17'h00, 1'b0, '0);
    add_row(1'b0, 17'hFF, 1'b0, '0);
    add_row(1'b0, 17'h00, 1'b0, '0);
    add_row(1'b0, 17'h00, 1'b0, '0);
    add_row(1'b0, 17'h00, 1'b1, res(EV_NO_TAIL, 8'h00, 8'hFF, 8'h00, 16'd0, 1'b1));
    add_row(1'b1, 17'd7, 1'b0, '0);
    add_row(1'b0, 17'hAA, 1'b0, '0);
    add_row(1'b0, 17'h41, 1'b0, '0);
    add_row(1'b0, 17'h01, 1'b0, '0);
    add_row(1'b0, 17'h02, 1'b0, '0);
    add_row(1'b0, 17'h01, 1'b0, '0);
    add_row(1'b0, 17'h00, 1'b0, '0);
    add_row(1'b0, 17'h7E, 1'b0, '0);
    add_row(1'b0, 17'hFF, 1'b1, res(EV_TOO_LONG, 8'h00, 8'h02, 8'h01, 16'd1, 1'b1));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        program_max_len(script[i].value);
      end else begin
        send_byte(script[i].value[7:0], script[i].typed, script[i].want);
      end
    end

    p = 0;
    while (bytes_sent < 1830) begin
      case (p)
        0:       program_max_len(17'd0);
        1:       program_max_len(17'd6);
        2:       program_max_len(17'd7);
        3:       program_max_len(17'd8);
        4:       program_max_len(17'd65542);
        5:       program_max_len(17'h1FFFF);
        6:       program_max_len(17'd20);
        default: begin
          case ($urandom_range(0, 2))
            0:       program_max_len(17'($urandom_range(7, 40)));
            1:       program_max_len(17'($urandom_range(7, 65542)));
            default: program_max_len(17'($urandom));
          endcase
        end
      endcase
      // Hold the receiver off for a long stretch while bytes keep coming.
      if (p == 2) stall_req++;
      random_phase(p);
      p++;
    end

    // One frame whose whole length equals the limit exactly.
    program_max_len(17'd27);
    build_frame(20, 1'b1);
    send_frame_bytes();

    @(negedge clk);
    in_valid_i = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("packet_deframer_top_test: clean");
    end else begin
      $display("packet_deframer_top_test: errors");
    end
    $finish;
  end

endmodule
